@@ rtl/core/averaging_thermostat_controller_unit_macros.svh @@
// Assertion helpers for the thermostat controller, included by atcu_ctrl.
`ifndef AVERAGING_THERMOSTAT_CONTROLLER_UNIT_MACROS_SVH
`define AVERAGING_THERMOSTAT_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ATCU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ATCU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/atcu_pkg.sv @@
`default_nettype none
package atcu_pkg;

	localparam int WINDOW      = 10;
	localparam int SAMPLE_W    = 10;
	localparam int SETPOINT_W  = 10;
	localparam int BYTE_W      = 8;
	localparam int SUM_W       = 14;
	localparam int CNT_W       = 4;
	localparam int STEP_W      = $clog2(SUM_W);
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 10;

	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_UP     = 2'd1;
	localparam logic [1:0] REQ_DOWN   = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_MIN_SETPOINT     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_SETPOINT     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND         = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT_STEP    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_SETPOINT = 3'd4;

	localparam logic [SETPOINT_W-1:0] MIN_SETPOINT_RST = 10'd35;
	localparam logic [SETPOINT_W-1:0] MAX_SETPOINT_RST = 10'd75;
	localparam logic [BYTE_W-1:0]     DEADBAND_RST     = 8'd5;
	localparam logic [BYTE_W-1:0]     STEP_RST         = 8'd5;
	localparam logic [SETPOINT_W-1:0] SETPOINT_RST     = 10'd60;

	typedef struct packed {
		logic [SETPOINT_W-1:0] min_setpoint;
		logic [SETPOINT_W-1:0] max_setpoint;
		logic [BYTE_W-1:0]     deadband;
		logic [BYTE_W-1:0]     setpoint_step;
	} atcu_cfg_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic publish;
	} atcu_cmd_t;

	typedef struct packed {
		logic in_sample;
		logic out_free;
	} atcu_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/atcu_ctrl.sv @@
`default_nettype none
`include "averaging_thermostat_controller_unit_macros.svh"
module atcu_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  atcu_pkg::atcu_sts_t sts,
	output atcu_pkg::atcu_cmd_t cmd
);
	import atcu_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

	logic [1:0]        state_q;
	logic [1:0]        state_d;
	logic [STEP_W-1:0] step_q;

	assign in_stall     = (state_q != ST_IDLE);
	assign cmd.load     = in_valid && (state_q == ST_IDLE);
	assign cmd.div_step = (state_q == ST_DIV);
	assign cmd.publish  = (state_q == ST_DONE) && sts.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = sts.in_sample ? ST_DIV : ST_DONE;
				end
			end
			ST_DIV: begin
				if (step_q == LAST_STEP) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				step_q <= (step_q == LAST_STEP) ? '0 : step_q + 1'b1;
			end
		end
	end

	`ATCU_ASSERT_NOW(a_publish_free, cmd.publish, sts.out_free, "result written while output busy")
	`ATCU_ASSERT_NOW(a_load_no_step, cmd.load, !cmd.div_step && !cmd.publish, "load overlaps work")
	`ATCU_ASSERT_NEXT(a_sample_divides, cmd.load && sts.in_sample, state_q == ST_DIV, "no divide")
	`ATCU_ASSERT_NOW(a_step_range, state_q == ST_DIV, step_q <= LAST_STEP, "step count overrun")
	`ATCU_ASSERT_NOW(a_step_idle, state_q != ST_DIV, step_q == '0, "step count not cleared")

endmodule
`default_nettype wire

@@ rtl/core/atcu_dp.sv @@
`default_nettype none
module atcu_dp (
	input  wire                                clk,
	input  wire                                arst_n,
	input  atcu_pkg::atcu_cfg_t                cfg,
	input  atcu_pkg::atcu_cmd_t                cmd,
	output atcu_pkg::atcu_sts_t                sts,
	input  wire  [1:0]                         req_type,
	input  wire  [atcu_pkg::SAMPLE_W-1:0]      sample,
	input  wire                                blink_phase,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic                               heater_on,
	output logic                               cooler_on,
	output logic                               led_on,
	output logic [atcu_pkg::SETPOINT_W-1:0]    average_out,
	output logic [atcu_pkg::SETPOINT_W-1:0]    setpoint_out
);
	import atcu_pkg::*;

	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SETPOINT_W-1:0] average_q;
	logic [SETPOINT_W-1:0] setpoint_q;
	logic [1:0]            kind_q;
	logic                  blink_q;
	logic [SUM_W-1:0]      quo_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W-1:0]      dvsr_q;

	logic [SUM_W-1:0]      sum_nx;
	logic [CNT_W-1:0]      cnt_nx;
	logic [CNT_W:0]        trial;
	logic                  fits;
	logic [SETPOINT_W:0]   sp_up;
	logic [SETPOINT_W-1:0] avg_new;
	logic [SETPOINT_W:0]   spx;
	logic [SETPOINT_W:0]   avgx;
	logic [SETPOINT_W:0]   dbx;
	logic                  above_lo;
	logic                  below_hi;
	logic                  in_band;

	assign sts.in_sample = (req_type == REQ_SAMPLE);
	assign sts.out_free  = !out_valid || !out_stall;

	assign sum_nx = sum_q + SUM_W'(sample);
	assign cnt_nx = cnt_q + 1'b1;
	assign trial  = {rem_q, quo_q[SUM_W-1]};
	assign fits   = trial >= {1'b0, dvsr_q};
	assign sp_up  = {1'b0, setpoint_q} + (SETPOINT_W+1)'(cfg.setpoint_step);

	assign avg_new  = quo_q[SETPOINT_W-1:0];
	assign spx      = {1'b0, setpoint_q};
	assign avgx     = {1'b0, avg_new};
	assign dbx      = (SETPOINT_W+1)'(cfg.deadband);
	assign above_lo = (spx + dbx) > avgx;
	assign below_hi = spx < (avgx + dbx);
	assign in_band  = above_lo && below_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			cnt_q      <= '0;
			average_q  <= '0;
			setpoint_q <= SETPOINT_RST;
			out_valid  <= 1'b0;
		end else begin
			out_valid <= cmd.publish || (out_valid && out_stall);
			if (cmd.load) begin
				unique case (req_type)
					REQ_SAMPLE: begin
						if (cnt_nx == CNT_W'(WINDOW)) begin
							sum_q <= '0;
							cnt_q <= '0;
						end else begin
							sum_q <= sum_nx;
							cnt_q <= cnt_nx;
						end
					end
					REQ_UP: begin
						if (setpoint_q < cfg.max_setpoint) begin
							setpoint_q <= sp_up[SETPOINT_W] ? '1 : sp_up[SETPOINT_W-1:0];
						end
					end
					REQ_DOWN: begin
						if (setpoint_q > cfg.min_setpoint) begin
							setpoint_q <= (setpoint_q > SETPOINT_W'(cfg.setpoint_step))
								? setpoint_q - SETPOINT_W'(cfg.setpoint_step) : '0;
						end
					end
					default: ;
				endcase
			end
			if (cmd.publish && (kind_q == REQ_SAMPLE)) begin
				average_q <= avg_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= req_type;
			blink_q <= blink_phase;
			quo_q   <= sum_nx;
			rem_q   <= '0;
			dvsr_q  <= cnt_nx;
		end else if (cmd.div_step) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, dvsr_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
		if (cmd.publish) begin
			setpoint_out <= setpoint_q;
			if (kind_q == REQ_SAMPLE) begin
				heater_on   <= !in_band && !below_hi;
				cooler_on   <= !in_band && below_hi;
				led_on      <= (!in_band && below_hi) || (!in_band && !below_hi && blink_q);
				average_out <= avg_new;
			end else begin
				heater_on   <= 1'b0;
				cooler_on   <= 1'b0;
				led_on      <= 1'b0;
				average_out <= average_q;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/averaging_thermostat_controller_unit.sv @@
// A temperature sample passes a load step, the bit-serial sum/count divider and a result
// step; a button request passes the load and result steps only. The result step waits
// while the output register is held. One request at a time; the next request is taken
// while the previous result waits in the output register.
// Reset: asynchronous, active low; sum, count and average clear, setpoint loads 60,
// limits, deadband and step return to 35, 75, 5 and 5.
`default_nettype none
module averaging_thermostat_controller_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [atcu_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire  [atcu_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [1:0]                         req_type,
	input  wire  [atcu_pkg::SAMPLE_W-1:0]      sample,
	input  wire                                blink_phase,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic                               heater_on,
	output logic                               cooler_on,
	output logic                               led_on,
	output logic [atcu_pkg::SETPOINT_W-1:0]    average_out,
	output logic [atcu_pkg::SETPOINT_W-1:0]    setpoint_out
);
	import atcu_pkg::*;

	atcu_cfg_t cfg_q;
	atcu_cmd_t cmd;
	atcu_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_setpoint  <= MIN_SETPOINT_RST;
			cfg_q.max_setpoint  <= MAX_SETPOINT_RST;
			cfg_q.deadband      <= DEADBAND_RST;
			cfg_q.setpoint_step <= STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_SETPOINT:     cfg_q.min_setpoint  <= cfg_data[SETPOINT_W-1:0];
				REG_MAX_SETPOINT:     cfg_q.max_setpoint  <= cfg_data[SETPOINT_W-1:0];
				REG_DEADBAND:         cfg_q.deadband      <= cfg_data[BYTE_W-1:0];
				REG_SETPOINT_STEP:    cfg_q.setpoint_step <= cfg_data[BYTE_W-1:0];
				// reset always reloads the setpoint from its fixed default
				REG_INITIAL_SETPOINT: ;
				default: ;
			endcase
		end
	end

	atcu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	atcu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.sample       (sample),
		.blink_phase  (blink_phase),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.heater_on    (heater_on),
		.cooler_on    (cooler_on),
		.led_on       (led_on),
		.average_out  (average_out),
		.setpoint_out (setpoint_out)
	);

endmodule
`default_nettype wire

@@ sim/thermostat_checker.sv @@
`default_nettype none
module thermostat_checker (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [atcu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire  [atcu_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                              in_valid,
	input  wire                              in_stall,
	input  wire  [1:0]                       req_type,
	input  wire  [atcu_pkg::SAMPLE_W-1:0]    sample,
	input  wire                              blink_phase,
	input  wire                              out_valid,
	input  wire                              out_stall,
	input  wire                              heater_on,
	input  wire                              cooler_on,
	input  wire                              led_on,
	input  wire  [atcu_pkg::SETPOINT_W-1:0]  average_out,
	input  wire  [atcu_pkg::SETPOINT_W-1:0]  setpoint_out,
	output int                               errors,
	output int                               outstanding
);
	import atcu_pkg::*;

	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic                  heater;
		logic                  cooler;
		logic                  led;
		logic [SETPOINT_W-1:0] average;
		logic [SETPOINT_W-1:0] setpoint;
	} reading_t;

	logic [SETPOINT_W-1:0] lim_min;
	logic [SETPOINT_W-1:0] lim_max;
	logic [BYTE_W-1:0]     band;
	logic [BYTE_W-1:0]     step_size;
	logic [SUM_W-1:0]      run_sum;
	logic [CNT_W-1:0]      run_count;
	logic [SETPOINT_W-1:0] avg_now;
	logic [SETPOINT_W-1:0] setpoint_now;

	reading_t expected_readings[$];
	reading_t want;

	initial errors = 0;

	task automatic report_mismatch(input string what, input int got, input int wanted);
		if (errors < PRINT_LIMIT)
			$display("%0t: %s got %0d expected %0d", $time, what, got, wanted);
		errors = errors + 1;
	endtask

	function automatic reading_t next_reading(input logic [1:0] kind,
			input logic [SAMPLE_W-1:0] value, input logic blink);
		reading_t r;
		int lo, hi, sp;
		logic [SETPOINT_W:0] raised;
		r = '0;
		case (kind)
		REQ_SAMPLE: begin
			run_sum = run_sum + value;
			run_count = run_count + 1'b1;
			if (run_count != 0)
				avg_now = SETPOINT_W'(run_sum / run_count);
			if (run_count == WINDOW) begin
				run_count = '0;
				run_sum = '0;
			end
			sp = int'(setpoint_now);
			lo = int'(avg_now) - int'(band);
			hi = int'(avg_now) + int'(band);
			if (!(sp < hi && sp > lo)) begin
				if (sp < hi) begin
					r.cooler = 1'b1;
					r.led = 1'b1;
				end else begin
					r.heater = 1'b1;
					r.led = blink;
				end
			end
		end
		REQ_UP: begin
			if (setpoint_now < lim_max) begin
				raised = {1'b0, setpoint_now} + step_size;
				setpoint_now = raised[SETPOINT_W] ? '1 : raised[SETPOINT_W-1:0];
			end
		end
		REQ_DOWN: begin
			if (setpoint_now > lim_min)
				setpoint_now = (setpoint_now > step_size) ? setpoint_now - step_size : '0;
		end
		default: ;
		endcase
		r.average = avg_now;
		r.setpoint = setpoint_now;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_min = MIN_SETPOINT_RST;
			lim_max = MAX_SETPOINT_RST;
			band = DEADBAND_RST;
			step_size = STEP_RST;
			run_sum = '0;
			run_count = '0;
			avg_now = '0;
			setpoint_now = SETPOINT_RST;
			expected_readings.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_MIN_SETPOINT: lim_min = cfg_data[SETPOINT_W-1:0];
				REG_MAX_SETPOINT: lim_max = cfg_data[SETPOINT_W-1:0];
				REG_DEADBAND: band = cfg_data[BYTE_W-1:0];
				REG_SETPOINT_STEP: step_size = cfg_data[BYTE_W-1:0];
				REG_INITIAL_SETPOINT: ;
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					report_mismatch("result with no request, setpoint_out", setpoint_out, 0);
				end else begin
					want = expected_readings.pop_front();
					if (heater_on !== want.heater)
						report_mismatch("heater_on", heater_on, want.heater);
					if (cooler_on !== want.cooler)
						report_mismatch("cooler_on", cooler_on, want.cooler);
					if (led_on !== want.led)
						report_mismatch("led_on", led_on, want.led);
					if (average_out !== want.average)
						report_mismatch("average_out", average_out, want.average);
					if (setpoint_out !== want.setpoint)
						report_mismatch("setpoint_out", setpoint_out, want.setpoint);
				end
			end
			if (in_valid && !in_stall)
				expected_readings.push_back(next_reading(req_type, sample, blink_phase));
			outstanding <= int'(expected_readings.size());
		end
	end

endmodule
`default_nettype wire

@@ sim/tb_averaging_thermostat_controller_unit.sv @@
`default_nettype none
module tb_averaging_thermostat_controller_unit;
	import atcu_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 128;
	localparam int QUIET_LIMIT = 1000;
	localparam int TAIL_CYCLES = 40;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [1:0]             req_type;
	logic [SAMPLE_W-1:0]    sample;
	logic                   blink_phase;
	logic                   out_valid;
	logic                   out_stall;
	logic                   heater_on;
	logic                   cooler_on;
	logic                   led_on;
	logic [SETPOINT_W-1:0]  average_out;
	logic [SETPOINT_W-1:0]  setpoint_out;

	int errors;
	int outstanding;
	int send_idle;
	int recv_idle;
	int cur_band;
	int quiet;
	logic [SETPOINT_W-1:0] last_setpoint = SETPOINT_RST;

	averaging_thermostat_controller_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.sample      (sample),
		.blink_phase (blink_phase),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.heater_on   (heater_on),
		.cooler_on   (cooler_on),
		.led_on      (led_on),
		.average_out (average_out),
		.setpoint_out(setpoint_out)
	);

	thermostat_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.sample      (sample),
		.blink_phase (blink_phase),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.heater_on   (heater_on),
		.cooler_on   (cooler_on),
		.led_on      (led_on),
		.average_out (average_out),
		.setpoint_out(setpoint_out),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			last_setpoint <= setpoint_out;
	end

	task automatic send_request(input logic [1:0] kind, input logic [SAMPLE_W-1:0] value,
			input logic blink);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		sample <= value;
		blink_phase <= blink;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (outstanding == 0);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] lo_limit,
			input logic [CFG_DATA_W-1:0] hi_limit, input logic [CFG_DATA_W-1:0] band,
			input logic [CFG_DATA_W-1:0] step);
		write_register(REG_MIN_SETPOINT, lo_limit);
		write_register(REG_MAX_SETPOINT, hi_limit);
		write_register(REG_DEADBAND, band);
		write_register(REG_SETPOINT_STEP, step);
		write_register(REG_INITIAL_SETPOINT, CFG_DATA_W'($urandom_range(SAMPLE_MAX)));
		cur_band = int'(band[BYTE_W-1:0]);
	endtask

	task automatic run_random(input int count);
		int base, spread, value, pick;
		logic [1:0] kind;
		base = 0;
		spread = 0;
		for (int n = 0; n < count; n++) begin
			if (n % 12 == 0) begin
				base = $urandom_range(1) ? int'(last_setpoint) : int'($urandom_range(SAMPLE_MAX));
				spread = int'($urandom_range(cur_band + 6));
			end
			if ($urandom_range(63) == 0)
				wait_for_results();
			pick = int'($urandom_range(99));
			if (pick < 70)
				kind = REQ_SAMPLE;
			else if (pick < 82)
				kind = REQ_UP;
			else if (pick < 94)
				kind = REQ_DOWN;
			else
				kind = REQ_UNUSED;
			if (kind == REQ_SAMPLE) begin
				value = base - spread + int'($urandom_range(2 * spread));
				if (value < 0)
					value = 0;
				else if (value > SAMPLE_MAX)
					value = SAMPLE_MAX;
			end else begin
				value = int'($urandom_range(SAMPLE_MAX));
			end
			send_request(kind, SAMPLE_W'(value), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_SAMPLE;
		sample = '0;
		blink_phase = 1'b0;
		out_stall = 1'b0;
		send_idle = 26;
		recv_idle = 52;
		cur_band = int'(DEADBAND_RST);
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		send_request(REQ_SAMPLE, '0, 1'b0);
		send_request(REQ_SAMPLE, '1, 1'b1);
		send_request(REQ_UNUSED, '1, 1'b1);
		repeat (4) send_request(REQ_UP, '0, 1'b0);
		repeat (2) send_request(REQ_DOWN, '1, 1'b1);
		for (int k = 0; k < 8; k++)
			send_request(REQ_SAMPLE, k[0] ? '1 : '0, k[0]);

		for (int p = 0; p < PHASES; p++) begin
			wait_for_results();
			if (p == 4) begin
				send_idle = 52;
				recv_idle = 26;
			end
			if (p == 7) begin
				send_idle = 0;
				recv_idle = 0;
			end
			case (p)
			0: apply_settings(10'd0, 10'd1023, 10'd0, 10'd255);
			1: apply_settings(10'd0, 10'd1023, 10'd255, 10'd1);
			2: apply_settings(10'd600, 10'd200, 10'd20, 10'd37);
			3: apply_settings(10'd1023, 10'd0, 10'h3FF, 10'h101);
			4: apply_settings(10'd35, 10'd75, 10'h305, 10'd5);
			default: apply_settings(CFG_DATA_W'($urandom_range(SAMPLE_MAX)),
					CFG_DATA_W'($urandom_range(SAMPLE_MAX)),
					CFG_DATA_W'($urandom_range(SAMPLE_MAX)),
					{2'($urandom_range(3)), 8'($urandom_range(255, 1))});
			endcase
			if (p == 0) begin
				// window is empty here: one sample equal to the setpoint, zero band
				send_request(REQ_SAMPLE, last_setpoint, 1'b1);
				repeat (4) send_request(REQ_UP, '1, 1'b0);
				repeat (5) send_request(REQ_DOWN, '0, 1'b1);
			end
			run_random(PHASE_ITEMS);
		end

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/atcu_pkg.sv
rtl/core/atcu_ctrl.sv
rtl/core/atcu_dp.sv
rtl/core/averaging_thermostat_controller_unit.sv
sim/thermostat_checker.sv
sim/tb_averaging_thermostat_controller_unit.sv
